/* design/lhp_pkg.sv */
package lhp_pkg;

   localparam int NUM_BUCKETS     = 4096;
   localparam int BUCKET_WIDTH_US = 1;
   localparam int NUM_PERCENTILES = 6;

   localparam int IDX_W      = $clog2(NUM_BUCKETS);
   localparam int CNT_W      = 32;
   localparam int SUM_W      = CNT_W + IDX_W;
   localparam int TOTAL_W    = 44;
   localparam int FRAC_W     = 25;
   localparam int FRAC_BITS  = 24;
   localparam int OFFSET_W   = 16;
   localparam int NS_W       = 32;
   localparam int US_W       = 23;
   localparam int LAT_W      = 24;
   localparam int RANK_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 25;
   localparam int NUM_FRAC_REGS = 6;
   localparam int HI_W       = TOTAL_W - FRAC_BITS;
   localparam int GOAL_W     = HI_W + FRAC_W + 1;

   localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   // ns -> us: floor(ns / 1000) = (ns * ceil(2^38 / 1000)) >> 38, exact for 32-bit ns
   localparam int NS_RECIP_W = 29;
   localparam int NS_SHIFT   = 38;
   localparam logic [NS_RECIP_W-1:0] NS_RECIP = 29'd274877907;

   // us -> bucket: floor(us / BUCKET_WIDTH_US) by reciprocal, exact for 23-bit us
   localparam int BW_SHIFT   = 33;
   localparam int BW_RECIP_W = 34;
   localparam logic [BW_RECIP_W-1:0] BW_RECIP =
      BW_RECIP_W'(((64'd1 << BW_SHIFT) + 64'(BUCKET_WIDTH_US) - 64'd1) / 64'(BUCKET_WIDTH_US));

   typedef logic [FRAC_W-1:0] frac_type;
   typedef logic [GOAL_W-1:0] goal_type;
   typedef logic [IDX_W-1:0]  idx_type;

   localparam frac_type FRAC_RESET [NUM_FRAC_REGS] = '{
      25'd8388608, 25'd15099494, 25'd15938355,
      25'd16609444, 25'd16760438, 25'd16775539
   };

   typedef enum logic {
      OP_RECORD = 1'b0,
      OP_REPORT = 1'b1
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_OFFSET = 3'd0,
      CSR_PCT_FRAC_0   = 3'd1,
      CSR_PCT_FRAC_1   = 3'd2,
      CSR_PCT_FRAC_2   = 3'd3,
      CSR_PCT_FRAC_3   = 3'd4,
      CSR_PCT_FRAC_4   = 3'd5,
      CSR_PCT_FRAC_5   = 3'd6
   } csr_index_type;

   // bucket update request from the binning pipeline
   typedef struct packed {
      logic    vld;
      idx_type idx;
      logic    busy;
   } bin_req_type;

endpackage

/* design/latency_histogram_percentiles_unit.sv */
// Channel  Direction  Handshake                Payload
// req      in         req_valid / req_ready    req_opcode, req_latency_ns
// rsp      out        rsp_valid / rsp_ready    rsp_rank, rsp_latency_us, rsp_last
// csr      in         csr_we (no wait)         csr_index, csr_wdata
//
// Record items are taken one per cycle while req_ready is high; each passes the
// bin-map stages s1 to s4 and is then read-modified-written in the bucket RAM, a
// write bypass covering back-to-back hits on one bucket.
// A report drains the record pipeline, computes the goals, then scans and clears
// every bucket through the RAM read port and emits its results one per cycle as
// rsp_ready allows.
// req_ready is low from a report's acceptance until its last result is taken.
// After reset a clearing pass zeroes every RAM bucket with req_ready low; csr
// writes are taken at any time.
module latency_histogram_percentiles_unit
   import lhp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_opcode,
   input  logic [NS_W-1:0]         req_latency_ns,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [RANK_W-1:0]       rsp_rank,
   output logic signed [LAT_W-1:0] rsp_latency_us,
   output logic                    rsp_last,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_DRAIN,
      ST_GOAL,
      ST_SCAN,
      ST_EMIT
   } state_type;

   localparam int SCNT_W = IDX_W + 1;
   localparam int CMP_W  = (SUM_W > GOAL_W) ? SUM_W : GOAL_W;
   localparam int LCALC_W = 40;

   state_type           state_ff;
   logic [SCNT_W-1:0]   cnt_ff;
   logic [OFFSET_W-1:0] offset_ff;
   frac_type            frac_ff [NUM_FRAC_REGS];
   logic [TOTAL_W-1:0]  total_ff;

   logic                rmw_vld_ff, scn_vld_ff, scn_last_ff;
   idx_type             rmw_addr_ff;
   logic                byp_vld_ff, byp_vld_in;
   logic [CNT_W-1:0]    byp_data_ff;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic                found_ff [NUM_PERCENTILES];
   idx_type             pidx_ff  [NUM_PERCENTILES];
   logic                hit      [NUM_PERCENTILES];
   logic                goal_start_ff;
   logic [RANK_W-1:0]   emit_j_ff;

   logic                rsp_valid_ff, rsp_last_ff;
   logic [RANK_W-1:0]   rsp_rank_ff;
   logic [LAT_W-1:0]    rsp_lat_ff, rsp_lat_in;

   bin_req_type         bin_out;
   goal_type            goal [NUM_PERCENTILES];
   logic                goal_done;

   logic                req_acc, rec_acc, scan_issue;
   logic                rd_en, wr_en;
   idx_type             rd_addr, wr_addr;
   logic [CNT_W-1:0]    wr_data, ram_q, cur_q;
   idx_type             sel_idx;
   logic [LCALC_W-1:0]  lat_calc;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign rec_acc   = req_acc && (req_opcode == OP_RECORD);

   lhp_bin_map u_bin_map (
      .clock  (clock),
      .reset  (reset),
      .in_vld (rec_acc),
      .in_ns  (req_latency_ns),
      .offset (offset_ff),
      .out    (bin_out)
   );

   lhp_goal u_goal (
      .clock (clock),
      .reset (reset),
      .start (goal_start_ff),
      .total (total_ff),
      .frac  (frac_ff),
      .goal  (goal),
      .done  (goal_done)
   );

   lhp_ram #(
      .DEPTH  (NUM_BUCKETS),
      .DATA_W (CNT_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // read port: scan owns it during a report, record updates otherwise
   assign scan_issue = (state_ff == ST_SCAN) && (cnt_ff < SCNT_W'(NUM_BUCKETS));
   assign rd_en      = bin_out.vld || scan_issue;
   assign rd_addr    = scan_issue ? cnt_ff[IDX_W-1:0] : bin_out.idx;

   // forward a write that landed in the same cycle as this entry's read
   assign cur_q = byp_vld_ff ? byp_data_ff : ram_q;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rmw_addr_ff;
      wr_data = '0;
      if (state_ff == ST_INIT) begin
         wr_en   = 1'b1;
         wr_addr = cnt_ff[IDX_W-1:0];
      end else if (rmw_vld_ff) begin
         wr_en   = (cur_q != CNT_MAX);
         wr_data = cur_q + 1'b1;
      end else if (scn_vld_ff) begin
         wr_en   = 1'b1;
      end
   end

   assign byp_vld_in = wr_en && rd_en && (wr_addr == rd_addr);
   assign sum_in     = sum_ff + SUM_W'(cur_q);

   always_comb begin
      for (int j = 0; j < NUM_PERCENTILES; j++) begin
         hit[j] = !found_ff[j] && (CMP_W'(sum_in) >= CMP_W'(goal[j]));
      end
   end

   assign sel_idx  = pidx_ff[emit_j_ff];
   assign lat_calc = LCALC_W'(sel_idx) * LCALC_W'(BUCKET_WIDTH_US) + LCALC_W'(offset_ff);
   assign rsp_lat_in = (sel_idx == IDX_W'(NUM_BUCKETS - 1)) ? '1 : lat_calc[LAT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         cnt_ff        <= '0;
         offset_ff     <= '0;
         frac_ff       <= FRAC_RESET;
         total_ff      <= '0;
         rmw_vld_ff    <= 1'b0;
         scn_vld_ff    <= 1'b0;
         scn_last_ff   <= 1'b0;
         byp_vld_ff    <= 1'b0;
         goal_start_ff <= 1'b0;
         emit_j_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rmw_vld_ff    <= bin_out.vld;
         scn_vld_ff    <= scan_issue;
         scn_last_ff   <= scan_issue && (cnt_ff == SCNT_W'(NUM_BUCKETS - 1));
         byp_vld_ff    <= byp_vld_in;
         goal_start_ff <= (state_ff == ST_DRAIN) && !bin_out.busy && !rmw_vld_ff;

         if (csr_we) begin
            unique case (csr_index)
               CSR_START_OFFSET: offset_ff  <= csr_wdata[OFFSET_W-1:0];
               CSR_PCT_FRAC_0:   frac_ff[0] <= csr_wdata[FRAC_W-1:0];
               CSR_PCT_FRAC_1:   frac_ff[1] <= csr_wdata[FRAC_W-1:0];
               CSR_PCT_FRAC_2:   frac_ff[2] <= csr_wdata[FRAC_W-1:0];
               CSR_PCT_FRAC_3:   frac_ff[3] <= csr_wdata[FRAC_W-1:0];
               CSR_PCT_FRAC_4:   frac_ff[4] <= csr_wdata[FRAC_W-1:0];
               CSR_PCT_FRAC_5:   frac_ff[5] <= csr_wdata[FRAC_W-1:0];
               default: ;
            endcase
         end

         if (rmw_vld_ff && (cur_q != CNT_MAX) && (total_ff != TOTAL_MAX)) begin
            total_ff <= total_ff + 1'b1;
         end

         unique case (state_ff)
            ST_INIT: begin
               if (cnt_ff[IDX_W-1:0] == IDX_W'(NUM_BUCKETS - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_IDLE;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_IDLE: begin
               if (req_acc && (req_opcode == OP_REPORT)) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               // wait until every record has landed in the RAM and the total
               if (!bin_out.busy && !rmw_vld_ff) begin
                  state_ff <= ST_GOAL;
               end
            end
            ST_GOAL: begin
               if (goal_done) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (scan_issue) begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
               if (scn_vld_ff && scn_last_ff) begin
                  total_ff  <= '0;
                  emit_j_ff <= '0;
                  state_ff  <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  if (rsp_valid_ff && rsp_last_ff) begin
                     rsp_valid_ff <= 1'b0;
                     state_ff     <= ST_IDLE;
                  end else begin
                     rsp_valid_ff <= 1'b1;
                     emit_j_ff    <= emit_j_ff + 1'b1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end

      if (rd_en) begin
         rmw_addr_ff <= rd_addr;
      end
      byp_data_ff <= wr_data;

      // scan bookkeeping: running sum and first bucket reaching each goal
      if (goal_done) begin
         sum_ff <= '0;
         for (int j = 0; j < NUM_PERCENTILES; j++) begin
            found_ff[j] <= 1'b0;
            pidx_ff[j]  <= IDX_W'(NUM_BUCKETS - 1);
         end
      end else if (scn_vld_ff) begin
         sum_ff <= sum_in;
         for (int j = 0; j < NUM_PERCENTILES; j++) begin
            if (hit[j]) begin
               found_ff[j] <= 1'b1;
               pidx_ff[j]  <= rmw_addr_ff;
            end
         end
      end

      if ((state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready)) begin
         rsp_rank_ff <= emit_j_ff;
         rsp_lat_ff  <= rsp_lat_in;
         rsp_last_ff <= (emit_j_ff == RANK_W'(NUM_PERCENTILES - 1));
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rank       = rsp_rank_ff;
   assign rsp_latency_us = signed'(rsp_lat_ff);
   assign rsp_last       = rsp_last_ff;

   a_rmw_scan_excl: assert property (@(posedge clock) disable iff (reset)
      !(rmw_vld_ff && scn_vld_ff))
      else $error("record update and scan share the RAM data stage");

   a_scan_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (!bin_out.busy && !rmw_vld_ff))
      else $error("record in flight during scan");

   a_last_rank: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_rank_ff == RANK_W'(NUM_PERCENTILES - 1)))
      else $error("last flag on wrong rank");

   a_total_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && scn_vld_ff && scn_last_ff) |=> (total_ff == '0))
      else $error("total not cleared after scan");

endmodule

/* design/lhp_ram.sv */
module lhp_ram #(
   parameter int DEPTH  = 4096,
   parameter int DATA_W = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/lhp_bin_map.sv */
module lhp_bin_map
   import lhp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_vld,
   input  logic [NS_W-1:0]     in_ns,
   input  logic [OFFSET_W-1:0] offset,
   output bin_req_type         out
);

   localparam int P1_W = NS_W + NS_RECIP_W;
   localparam int P2_W = US_W + BW_RECIP_W;

   logic              s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic [NS_W-1:0]   s1_ns_ff;
   logic [US_W-1:0]   s2_us_ff, s2_us_in;
   logic [US_W-1:0]   s3_rel_ff, s3_rel_in;
   logic              s3_under_ff, s3_under_in;
   logic [US_W-1:0]   s4_q_ff, s4_q_in;
   logic              s4_under_ff;
   logic [P1_W-1:0]   prod1;
   logic [P2_W-1:0]   prod2;

   assign prod1       = P1_W'(s1_ns_ff) * P1_W'(NS_RECIP);
   assign s2_us_in    = prod1[NS_SHIFT +: US_W];
   // below start wraps to the overflow bucket
   assign s3_under_in = s2_us_ff < US_W'(offset);
   assign s3_rel_in   = s2_us_ff - US_W'(offset);
   assign prod2       = P2_W'(s3_rel_ff) * P2_W'(BW_RECIP);
   assign s4_q_in     = prod2[BW_SHIFT +: US_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= in_vld;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
      if (in_vld) begin
         s1_ns_ff <= in_ns;
      end
      s2_us_ff    <= s2_us_in;
      s3_rel_ff   <= s3_rel_in;
      s3_under_ff <= s3_under_in;
      s4_q_ff     <= s4_q_in;
      s4_under_ff <= s3_under_ff;
   end

   always_comb begin
      out.vld  = s4_vld_ff;
      out.busy = s1_vld_ff | s2_vld_ff | s3_vld_ff | s4_vld_ff;
      if (s4_under_ff || (s4_q_ff >= US_W'(NUM_BUCKETS))) begin
         out.idx = IDX_W'(NUM_BUCKETS - 1);
      end else begin
         out.idx = s4_q_ff[IDX_W-1:0];
      end
   end

endmodule

/* design/lhp_goal.sv */
module lhp_goal
   import lhp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [TOTAL_W-1:0] total,
   input  frac_type           frac [NUM_FRAC_REGS],
   output goal_type           goal [NUM_PERCENTILES],
   output logic               done
);

   localparam int PHI_W = HI_W + FRAC_W;
   localparam int PLO_W = FRAC_BITS + FRAC_W;

   logic              act_ff;
   logic [RANK_W-1:0] cnt_ff;
   logic              p_vld_ff;
   logic [RANK_W-1:0] p_j_ff;
   logic [PHI_W-1:0]  p_hi_ff, p_hi_in;
   logic [PLO_W-1:0]  p_lo_ff, p_lo_in;
   logic              done_ff;
   goal_type          goal_ff [NUM_PERCENTILES];
   frac_type          cur_frac;

   // goal = hi * frac + ((lo * frac) >> 24), one fraction per cycle
   assign cur_frac = frac[cnt_ff];
   assign p_hi_in  = PHI_W'(total[TOTAL_W-1:FRAC_BITS]) * PHI_W'(cur_frac);
   assign p_lo_in  = PLO_W'(total[FRAC_BITS-1:0]) * PLO_W'(cur_frac);

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff   <= 1'b0;
         cnt_ff   <= '0;
         p_vld_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         p_vld_ff <= act_ff;
         done_ff  <= p_vld_ff && (p_j_ff == RANK_W'(NUM_PERCENTILES - 1));
         if (start) begin
            act_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (act_ff) begin
            if (cnt_ff == RANK_W'(NUM_PERCENTILES - 1)) begin
               act_ff <= 1'b0;
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
      end
      p_j_ff  <= cnt_ff;
      p_hi_ff <= p_hi_in;
      p_lo_ff <= p_lo_in;
      if (p_vld_ff) begin
         goal_ff[p_j_ff] <= GOAL_W'(p_hi_ff) + GOAL_W'(p_lo_ff >> FRAC_BITS);
      end
   end

   assign goal = goal_ff;
   assign done = done_ff;

endmodule
